@@ rtl/core/vil_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual IRQ list injector package
// Shared types, codes and sizes for the list injector controller and datapath.
// ----------------------------------------------------------------------------
package vil_pkg;

    localparam int LIST_REGS   = 16;
    localparam int QUEUE_DEPTH = 256;

    localparam int LR_W  = (LIST_REGS > 1) ? $clog2(LIST_REGS) : 1;
    localparam int LIM_W = $clog2(LIST_REGS + 1);
    localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [4:0] NUM_LR_RESET = 5'd4;

    typedef enum logic [1:0] {
        FUNC_INJECT = 2'd0,
        FUNC_DRAIN  = 2'd1,
        FUNC_RETIRE = 2'd2,
        FUNC_RSVD   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_WRITTEN = 3'd0,
        ST_DUP     = 3'd1,
        ST_QUEUED  = 3'd2,
        ST_DROPPED = 3'd3,
        ST_DRAINED = 3'd4,
        ST_FREED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INJ_SCAN,
        S_DRN_CHK,
        S_DRN_LOAD,
        S_DRN_SCAN,
        S_RETIRE
    } t_state;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] irq_id;
        logic [3:0] lr_index;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry_index;
        logic [31:0] entry_value;
        logic        maint_enable;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    load;
        logic    scan_clr;
        logic    scan_step;
        logic    place;
        logic    enqueue;
        logic    pop;
        logic    ld_ring_id;
        logic    retire;
        logic    flag_set;
        logic    flag_clr;
        logic    emit;
        t_status status;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;
        logic hit;
        logic have_free;
        logic ring_full;
        logic ring_empty;
    } t_dp_sts;

    // List register word: id, id again as physical id, pending and hw bits.
    function automatic logic [31:0] make_word(input logic [9:0] id);
        logic [31:0] w;
        w        = '0;
        w[9:0]   = id;
        w[19:10] = id;
        w[28]    = 1'b1;
        w[31]    = 1'b1;
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/vil_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// List injector controller
// Sequences inject scans, ring drains and retires by commanding the datapath.
// ----------------------------------------------------------------------------
module vil_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_func,
    input  wire vil_pkg::t_dp_sts i_sts,
    output vil_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy
);
    import vil_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    case (t_func'(i_func))
                        FUNC_INJECT: n_state = S_INJ_SCAN;
                        FUNC_DRAIN:  n_state = S_DRN_CHK;
                        FUNC_RETIRE: n_state = S_RETIRE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INJ_SCAN: begin
                o_cmd.last = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_DUP;
                    n_state      = S_IDLE;
                end else if (i_sts.scan_end) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_sts.have_free) begin
                        o_cmd.place  = 1'b1;
                        o_cmd.status = ST_WRITTEN;
                    end else if (!i_sts.ring_full) begin
                        o_cmd.enqueue  = 1'b1;
                        o_cmd.flag_set = 1'b1;
                        o_cmd.status   = ST_QUEUED;
                    end else begin
                        o_cmd.flag_set = 1'b1;
                        o_cmd.status   = ST_DROPPED;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DRN_CHK: begin
                if (i_sts.ring_empty) begin
                    o_cmd.flag_clr = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = ST_DRAINED;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DRN_LOAD;
                end
            end
            S_DRN_LOAD: begin
                o_cmd.ld_ring_id = 1'b1;
                o_cmd.scan_clr   = 1'b1;
                n_state          = S_DRN_SCAN;
            end
            S_DRN_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_DRN_CHK;
                end else if (i_sts.scan_end) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.have_free) begin
                        o_cmd.place  = 1'b1;
                        o_cmd.pop    = 1'b1;
                        o_cmd.status = ST_WRITTEN;
                        n_state      = S_DRN_CHK;
                    end else begin
                        o_cmd.flag_set = 1'b1;
                        o_cmd.status   = ST_DRAINED;
                        o_cmd.last     = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_RETIRE: begin
                o_cmd.retire = 1'b1;
                o_cmd.emit   = 1'b1;
                o_cmd.status = ST_FREED;
                o_cmd.last   = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/vil_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// List injector datapath
// List entries, overflow ring memory, scan pointer, flag and result register.
// ----------------------------------------------------------------------------
module vil_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [4:0]       i_cfg_data,
    input  wire vil_pkg::t_item   i_item,
    input  wire vil_pkg::t_dp_cmd i_cmd,
    output vil_pkg::t_dp_sts      o_sts,
    output logic                  o_res_valid,
    output vil_pkg::t_result      o_result
);
    import vil_pkg::*;

    logic [4:0]           r_num_lr;
    logic [LIST_REGS-1:0] r_busy;
    logic [9:0]           r_entry_id [LIST_REGS];
    logic [9:0]           r_ring [QUEUE_DEPTH];
    logic [9:0]           r_ring_rd;
    logic [QP_W-1:0]      r_head;
    logic [QP_W-1:0]      r_tail;
    logic                 r_flag;
    logic [9:0]           r_id;
    logic [3:0]           r_lri;
    logic [LIM_W-1:0]     r_idx;
    logic                 r_have_free;
    logic [LR_W-1:0]      r_first;
    logic                 r_res_valid;
    t_result              r_result;

    logic [LIM_W-1:0] lim;
    logic [LR_W-1:0]  idx_lo;
    logic             scan_end;
    logic [QP_W-1:0]  tail_nxt;
    logic [QP_W-1:0]  head_nxt;
    logic             flag_after;

    // Entries beyond the implemented count are treated as absent.
    assign lim      = (32'(r_num_lr) > LIST_REGS) ? LIM_W'(LIST_REGS) : LIM_W'(r_num_lr);
    assign idx_lo   = r_idx[LR_W-1:0];
    assign scan_end = (r_idx >= lim);
    assign tail_nxt = (32'(r_tail) == QUEUE_DEPTH - 1) ? '0 : r_tail + 1'b1;
    assign head_nxt = (32'(r_head) == QUEUE_DEPTH - 1) ? '0 : r_head + 1'b1;

    assign o_sts.scan_end   = scan_end;
    assign o_sts.hit        = !scan_end && r_busy[idx_lo] && (r_entry_id[idx_lo] == r_id);
    assign o_sts.have_free  = r_have_free;
    assign o_sts.ring_full  = (tail_nxt == r_head);
    assign o_sts.ring_empty = (r_head == r_tail);

    assign flag_after = i_cmd.flag_set ? 1'b1 : (i_cmd.flag_clr ? 1'b0 : r_flag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_lr    <= NUM_LR_RESET;
            r_busy      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_flag      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_lr <= i_cfg_data;
            end
            if (i_cmd.place) begin
                r_busy[r_first] <= 1'b1;
            end
            if (i_cmd.retire) begin
                for (int e = 0; e < LIST_REGS; e++) begin
                    if (int'(r_lri) == e) begin
                        r_busy[e] <= 1'b0;
                    end
                end
            end
            if (i_cmd.enqueue) begin
                r_tail <= tail_nxt;
            end
            if (i_cmd.pop) begin
                r_head <= head_nxt;
            end
            r_flag      <= flag_after;
            r_res_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_entry_id[r_first] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enqueue) begin
            r_ring[r_tail] <= r_id;
        end
        r_ring_rd <= r_ring[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id  <= i_item.irq_id;
            r_lri <= i_item.lr_index;
        end else if (i_cmd.ld_ring_id) begin
            r_id <= r_ring_rd;
        end
        if (i_cmd.scan_clr) begin
            r_idx       <= '0;
            r_have_free <= 1'b0;
            r_first     <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (!r_busy[idx_lo] && !r_have_free) begin
                r_have_free <= 1'b1;
                r_first     <= idx_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.status       <= i_cmd.status;
            r_result.maint_enable <= flag_after;
            r_result.last         <= i_cmd.last;
            case (i_cmd.status)
                ST_WRITTEN: begin
                    r_result.entry_index <= 4'(r_first);
                    r_result.entry_value <= make_word(r_id);
                end
                ST_DUP: begin
                    r_result.entry_index <= 4'(r_idx);
                    r_result.entry_value <= '0;
                end
                ST_FREED: begin
                    r_result.entry_index <= r_lri;
                    r_result.entry_value <= '0;
                end
                default: begin
                    r_result.entry_index <= '0;
                    r_result.entry_value <= '0;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

@@ rtl/core/virtual_irq_list_injector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An inject word scans one list entry per cycle (num_lr counted at most 16) before its result
// is given; a retire word goes straight through the retire state. A drain handles each ring id
// it takes in turn through the check, load and scan states.
// Throughput: one word at a time; busy stays high until the last result is issued, and each
// result is strobed for one cycle that the receiver cannot stall.
// Reset (synchronous, active low): all entries free, ring empty, flag clear, num_lr 4.
// ----------------------------------------------------------------------------
// Virtual IRQ list injector
// Places virtual interrupt ids into list entries, queues overflow in a ring and
// drains the ring back into free entries on request.
// ----------------------------------------------------------------------------
module virtual_irq_list_injector (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // Command channel: a word is taken when start is high and busy is low.
    input  wire logic           i_start,
    input  wire vil_pkg::t_item i_item,
    output logic                o_busy,
    // Result channel: one word per strobe, one cycle each.
    output logic                o_res_valid,
    output vil_pkg::t_result    o_result,
    // Configuration: num_lr, written whenever the enable is high.
    input  wire logic           i_cfg_we,
    input  wire logic [4:0]     i_cfg_data
);
    import vil_pkg::*;

    // The controller only keeps its state, issues commands and reads status; all other storage lives
    // in the datapath, including the result register that drives the outputs.
    // Ring and id storage are not cleared by reset; only written entries are read.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    vil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_item.func),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (o_busy)
    );

    vil_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

@@ dv/tb_virtual_irq_list_injector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual IRQ list injector testbench
// Drives inject, drain, retire and unused words through the command port
// with random idle bursts, and rewrites num_lr between phases while the
// block is quiet. A cycle-free model of the list entries, the overflow ring
// and the maintenance flag predicts every result word, and a monitor checks
// each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_virtual_irq_list_injector;
    import vil_pkg::*;

    // Quiet cycles required before a num_lr write. This covers an inject scan
    // over at most LIST_REGS entries and an ignored word, so it covers any
    // word that is still in flight without giving a result.
    localparam int SETTLE_CYCLES = 30;
    // Watchdog limit in cycles with no word accepted in either direction.
    // The longest legal silence is a drain that finds every ring id already
    // in the list: up to 255 ids removed without a result, each after a scan
    // of the list at num_lr 16.
    localparam int STALL_LIMIT   = 25000;
    // Cycles allowed after the last expected result before the verdict.
    localparam int TAIL_CYCLES   = 50;

    typedef enum logic [1:0] {
        PLACE_WRITTEN,
        PLACE_DUP,
        PLACE_FULL
    } t_place;

    // One entry of the driver's work list: a command word, a num_lr write,
    // or a pause until every predicted result has come back.
    typedef enum logic [1:0] {
        REQ_WORD,
        REQ_CFG,
        REQ_DRAIN_WAIT
    } t_req_kind;

    typedef struct {
        t_req_kind  kind;
        t_item      word;
        logic [4:0] cfg;
        int         gap;
    } t_req;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_start    = 1'b0;
    t_item      i_item     = '0;
    logic       i_cfg_we   = 1'b0;
    logic [4:0] i_cfg_data = '0;
    logic       o_busy;
    logic       o_res_valid;
    t_result    o_result;

    virtual_irq_list_injector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Model state: the list entries, the overflow ring and the flag, plus
    // the num_lr value the block holds.
    // ------------------------------------------------------------------
    logic [4:0] lr_count = NUM_LR_RESET;
    logic       lr_busy  [LIST_REGS];
    logic [9:0] lr_id    [LIST_REGS];
    logic [9:0] ovf_ring [QUEUE_DEPTH];
    logic [7:0] ovf_head = '0;
    logic [7:0] ovf_tail = '0;
    logic       maint_flag = 1'b0;

    t_result results_due[$];
    t_req    pending[$];
    int      words_queued = 0;
    int      words_taken  = 0;
    int      mismatches   = 0;

    initial begin
        for (int n = 0; n < LIST_REGS; n++) begin
            lr_busy[n] = 1'b0;
            lr_id[n]   = '0;
        end
    end

    // The list register word: pending bit 28, hw bit 31, and the id both as
    // the virtual id and as the physical id.
    function automatic logic [31:0] lr_word(input logic [9:0] id);
        return {1'b1, 2'b00, 1'b1, 8'h00, id, id};
    endfunction

    // Scan the usable entries. A busy entry with the same id wins even when
    // nothing is free; otherwise the lowest free entry takes the id.
    function automatic t_place place_id(input logic [9:0] id, output logic [3:0] idx);
        int   lim;
        int   first;
        logic have_free;
        lim       = (lr_count > LIST_REGS) ? LIST_REGS : int'(lr_count);
        first     = 0;
        have_free = 1'b0;
        idx       = '0;
        for (int n = 0; n < lim; n++) begin
            if (!lr_busy[n]) begin
                if (!have_free) begin
                    have_free = 1'b1;
                    first     = n;
                end
            end else if (lr_id[n] == id) begin
                idx = 4'(n);
                return PLACE_DUP;
            end
        end
        if (!have_free) begin
            return PLACE_FULL;
        end
        lr_busy[first] = 1'b1;
        lr_id[first]   = id;
        idx            = 4'(first);
        return PLACE_WRITTEN;
    endfunction

    // Every result carries the flag as it stands once the result is made.
    function automatic void owe_result(input t_status st, input logic [3:0] idx,
                                       input logic [31:0] val, input logic fin);
        t_result r;
        r.status       = st;
        r.entry_index  = idx;
        r.entry_value  = val;
        r.maint_enable = maint_flag;
        r.last         = fin;
        results_due.push_back(r);
    endfunction

    // Advance the model by one accepted command word.
    function automatic void model_word(input t_item w);
        t_place     r;
        logic [3:0] idx;
        logic [9:0] qid;
        logic [7:0] nt;
        logic       full;
        case (w.func)
            FUNC_INJECT: begin
                r = place_id(w.irq_id, idx);
                if (r == PLACE_WRITTEN) begin
                    owe_result(ST_WRITTEN, idx, lr_word(w.irq_id), 1'b1);
                end else if (r == PLACE_DUP) begin
                    owe_result(ST_DUP, idx, '0, 1'b1);
                end else begin
                    // No free entry: queue the id, or drop it when the ring
                    // already holds QUEUE_DEPTH - 1 ids. The flag is set in
                    // both cases.
                    nt = ovf_tail + 8'd1;
                    maint_flag = 1'b1;
                    if (nt != ovf_head) begin
                        ovf_ring[ovf_tail] = w.irq_id;
                        ovf_tail = nt;
                        owe_result(ST_QUEUED, '0, '0, 1'b1);
                    end else begin
                        owe_result(ST_DROPPED, '0, '0, 1'b1);
                    end
                end
            end
            FUNC_DRAIN: begin
                // Ring ids found as duplicates leave the ring silently; the
                // walk stops when no entry is free and the flag stays set.
                full = 1'b0;
                while (ovf_head != ovf_tail) begin
                    qid = ovf_ring[ovf_head];
                    r   = place_id(qid, idx);
                    if (r == PLACE_FULL) begin
                        full = 1'b1;
                        break;
                    end
                    if (r == PLACE_WRITTEN) begin
                        owe_result(ST_WRITTEN, idx, lr_word(qid), 1'b0);
                    end
                    ovf_head = ovf_head + 8'd1;
                end
                maint_flag = full;
                owe_result(ST_DRAINED, '0, '0, 1'b1);
            end
            FUNC_RETIRE: begin
                // An index past the list only answers freed; freeing a free
                // entry is harmless.
                if (int'(w.lr_index) < LIST_REGS) begin
                    lr_busy[w.lr_index] = 1'b0;
                end
                owe_result(ST_FREED, w.lr_index, '0, 1'b1);
            end
            default: begin
                // The unused code is ignored and gives no result.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver. All inputs change only here, once per edge, from values
    // worked out with blocking assignments first.
    // ------------------------------------------------------------------
    int gap_left = 0;
    int quiet    = 0;

    always @(posedge i_clk) begin
        t_req       head;
        logic       nxt_start;
        t_item      nxt_item;
        logic       nxt_we;
        logic [4:0] nxt_data;
        nxt_start = i_start;
        nxt_item  = i_item;
        nxt_we    = 1'b0;
        nxt_data  = i_cfg_data;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            gap_left  = 0;
            quiet     = 0;
        end else begin
            if (o_res_valid) begin
                quiet = 0;
            end else if (quiet < SETTLE_CYCLES) begin
                quiet++;
            end
            // A word is taken at this edge when start is high and busy low.
            if (i_start && !o_busy) begin
                model_word(i_item);
                words_taken++;
                quiet     = 0;
                nxt_start = 1'b0;
            end
            // With start free, either sit out an idle burst or serve the
            // next request. A new word may follow the accepted one at once,
            // so start stays high across back-to-back words.
            if (!nxt_start && !i_cfg_we) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() != 0) begin
                    head = pending[0];
                    case (head.kind)
                        REQ_WORD: begin
                            if (head.gap > 0) begin
                                gap_left       = head.gap - 1;
                                pending[0].gap = 0;
                            end else begin
                                nxt_start = 1'b1;
                                nxt_item  = head.word;
                                void'(pending.pop_front());
                            end
                        end
                        REQ_CFG: begin
                            // Only a quiet, idle block takes a new num_lr.
                            if (results_due.size() == 0 && !o_busy
                                    && quiet >= SETTLE_CYCLES) begin
                                nxt_we   = 1'b1;
                                nxt_data = head.cfg;
                                lr_count = head.cfg;
                                void'(pending.pop_front());
                            end
                        end
                        default: begin
                            if (results_due.size() == 0) begin
                                void'(pending.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
        i_start    <= nxt_start;
        i_item     <= nxt_item;
        i_cfg_we   <= nxt_we;
        i_cfg_data <= nxt_data;
    end

    // ------------------------------------------------------------------
    // Monitor. A strobed result is taken at the edge that ends its cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: status %0d index %0d value %h maint %b last %b",
                             o_result.status, o_result.entry_index, o_result.entry_value,
                             o_result.maint_enable, o_result.last);
                end
            end else begin
                want = results_due.pop_front();
                if (o_result.status !== want.status
                        || o_result.entry_index !== want.entry_index
                        || o_result.entry_value !== want.entry_value
                        || o_result.maint_enable !== want.maint_enable
                        || o_result.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch at %0t: status %0d/%0d index %0d/%0d",
                                 $realtime, o_result.status, want.status,
                                 o_result.entry_index, want.entry_index);
                        $display("  value %h/%h maint %b/%b last %b/%b (actual/expected)",
                                 o_result.entry_value, want.entry_value,
                                 o_result.maint_enable, want.maint_enable,
                                 o_result.last, want.last);
                    end
                end
            end
        end
    end

    // Watchdog: any accepted word on either side restarts the count.
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_res_valid || i_cfg_we) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_word(input t_func f, input logic [9:0] id,
                             input logic [3:0] idx, input int gap);
        t_req q;
        q.kind          = REQ_WORD;
        q.word.func     = f;
        q.word.irq_id   = id;
        q.word.lr_index = idx;
        q.cfg           = '0;
        q.gap           = gap;
        pending.push_back(q);
        words_queued++;
    endtask

    task automatic push_cfg(input logic [4:0] val);
        t_req q;
        q.kind = REQ_CFG;
        q.word = '0;
        q.cfg  = val;
        q.gap  = 0;
        pending.push_back(q);
    endtask

    task automatic push_wait();
        t_req q;
        q.kind = REQ_DRAIN_WAIT;
        q.word = '0;
        q.cfg  = '0;
        q.gap  = 0;
        pending.push_back(q);
    endtask

    function automatic int pick_gap(input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            return $urandom_range(1, 18);
        end
        return 0;
    endfunction

    // A phase of mixed words under one num_lr. Ids come mostly from a small
    // pool so that duplicates, full lists and ring traffic are common.
    task automatic gen_phase(input logic [4:0] cfg_val, input int n_words, input bit gaps);
        int         pick;
        logic [9:0] id;
        logic [3:0] idx;
        push_cfg(cfg_val);
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(0, 99);
            id   = ($urandom_range(0, 9) < 6) ? 10'($urandom_range(0, 11) ^ 12'h3f0)
                                              : 10'($urandom_range(0, 1023));
            idx  = 4'($urandom_range(0, 15));
            if (gaps && $urandom_range(0, 39) == 0) begin
                push_wait();
            end
            if (pick < 48) begin
                push_word(FUNC_INJECT, id, idx, pick_gap(gaps));
            end else if (pick < 73) begin
                push_word(FUNC_RETIRE, id, idx, pick_gap(gaps));
            end else if (pick < 93) begin
                push_word(FUNC_DRAIN, id, idx, pick_gap(gaps));
            end else begin
                push_word(FUNC_RSVD, id, idx, pick_gap(gaps));
            end
        end
    endtask

    initial begin
        // Directed part, starting from the reset value of four entries.
        push_word(FUNC_INJECT, 10'd0, 4'd0, 0);
        push_word(FUNC_INJECT, 10'd1023, 4'd15, 0);
        push_word(FUNC_INJECT, 10'd0, 4'd0, 3);      // duplicate with room left
        push_word(FUNC_INJECT, 10'd5, 4'd0, 0);
        push_word(FUNC_INJECT, 10'd6, 4'd0, 0);      // the list is now full
        push_word(FUNC_INJECT, 10'd1023, 4'd0, 0);   // duplicate before full
        push_word(FUNC_INJECT, 10'd7, 4'd0, 0);      // queued, flag set
        push_word(FUNC_INJECT, 10'd8, 4'd0, 2);
        push_word(FUNC_RETIRE, 10'd1023, 4'd15, 0);  // index beyond num_lr
        push_word(FUNC_RETIRE, 10'd0, 4'd0, 0);
        push_word(FUNC_DRAIN, 10'd0, 4'd0, 0);       // one placed, then full
        push_word(FUNC_RETIRE, 10'd0, 4'd1, 0);
        push_word(FUNC_RETIRE, 10'd0, 4'd1, 0);      // freeing a free entry
        push_word(FUNC_RSVD, 10'd1023, 4'd15, 0);    // unused code, no result
        push_word(FUNC_DRAIN, 10'd0, 4'd0, 0);       // ring empties, flag clears
        push_word(FUNC_DRAIN, 10'd0, 4'd0, 5);       // drain of an empty ring
        push_word(FUNC_INJECT, 10'd9, 4'd0, 0);
        push_word(FUNC_INJECT, 10'd9, 4'd0, 0);      // same id queued twice
        push_word(FUNC_RETIRE, 10'd0, 4'd2, 0);
        push_word(FUNC_DRAIN, 10'd0, 4'd0, 0);       // second copy dropped silently
        push_wait();
        push_cfg(5'd0);                              // no usable entry at all
        push_word(FUNC_INJECT, 10'd3, 4'd0, 0);
        push_cfg(5'd16);
        push_word(FUNC_DRAIN, 10'd0, 4'd0, 0);
        push_cfg(5'd31);                             // acts as LIST_REGS
        push_word(FUNC_INJECT, 10'd1023, 4'd0, 0);

        // Fill the overflow ring to the brim with num_lr at zero; the ring
        // holds 255 ids, so the last inject is dropped.
        push_cfg(5'd0);
        for (int i = 0; i < 256; i++) begin
            push_word(FUNC_INJECT, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)),
                      ($urandom_range(0, 15) == 0) ? $urandom_range(1, 18) : 0);
        end

        // A short random phase with idle bursts, then one without to end
        // the run.
        gen_phase(5'd16, 8, 1'b1);
        gen_phase(5'($urandom_range(1, 16)), 8, 1'b0);

        while (words_taken != words_queued || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
